// ----- hw/rtl/pbrld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PackBits run-length decoder package
// Shared types and constants for the decoder front end, queue and back end.
// ----------------------------------------------------------------------------
package pbrld_pkg;

    localparam int unsigned ROW_BYTES       = 256;
    localparam int unsigned BLOCK_ROWS      = 56;
    localparam int unsigned LEN_W           = 17;
    localparam int unsigned MAX_BLOCK_BYTES = 65536;

    localparam logic [LEN_W-1:0] BLOCK_LEN_MAX   = LEN_W'(MAX_BLOCK_BYTES);
    localparam logic [LEN_W-1:0] BLOCK_LEN_RESET = LEN_W'(ROW_BYTES * BLOCK_ROWS);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_SHORT   = 2'd2,
        ST_MID_RUN = 2'd3
    } status_t;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic [7:0] want;
        logic       last;
        logic       open;
    } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pbrld_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PackBits run-length decoder channel interfaces
// Valid/ready channels for compressed bytes, decoded runs and configuration.
// ----------------------------------------------------------------------------
interface pbrld_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_of_chunk;

    modport source (output valid, output code_byte, output last_of_chunk, input ready);
    modport sink   (input valid, input code_byte, input last_of_chunk, output ready);
endinterface

interface pbrld_run_if;
    logic       valid;
    logic       ready;
    logic [7:0] value;
    logic [7:0] run_length;
    logic       block_done;
    logic [1:0] status;

    modport source (output valid, output value, output run_length, output block_done,
                    output status, input ready);
    modport sink   (input valid, input value, input run_length, input block_done,
                    input status, output ready);
endinterface

interface pbrld_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] block_length;

    modport source (output valid, output block_length, input ready);
    modport sink   (input valid, input block_length, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pbrld_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PackBits run-length decoder front end
// Accepts compressed bytes, tracks header/literal/repeat phase and issues
// one command per byte that produces a result.
// ----------------------------------------------------------------------------
module pbrld_front
    import pbrld_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pbrld_code_if.sink  code,
    output logic        push,
    input  wire logic   push_ready,
    output cmd_t        push_cmd
);

    phase_t     phase_reg, phase_next;
    logic [7:0] lit_reg, lit_next;
    logic [7:0] rep_reg, rep_next;
    logic [7:0] lit_dec;
    logic       accept;
    phase_t     phase_after;

    assign code.ready = push_ready;
    assign accept     = code.valid && push_ready;
    assign lit_dec    = (lit_reg != 8'd0) ? lit_reg - 8'd1 : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            lit_reg   <= 8'd0;
            rep_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            rep_reg   <= rep_next;
        end
    end

    always_comb
    begin
        phase_after       = phase_reg;
        lit_next          = lit_reg;
        rep_next          = rep_reg;
        push_cmd.has_data = 1'b0;
        push_cmd.data     = code.code_byte;
        push_cmd.want     = 8'd0;
        push_cmd.last     = code.last_of_chunk;
        push_cmd.open     = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (code.code_byte[7])
                begin
                    rep_next    = 8'(9'd257 - {1'b0, code.code_byte});
                    phase_after = PH_REPEAT;
                end
                else
                begin
                    lit_next    = code.code_byte + 8'd1;
                    phase_after = PH_LITERAL;
                end
            end
            PH_REPEAT:
            begin
                push_cmd.has_data = 1'b1;
                push_cmd.want     = rep_reg;
                rep_next          = 8'd0;
                phase_after       = PH_HEADER;
            end
            PH_LITERAL:
            begin
                push_cmd.has_data = 1'b1;
                push_cmd.want     = 8'd1;
                lit_next          = lit_dec;
                if (lit_dec == 8'd0)
                begin
                    phase_after = PH_HEADER;
                end
            end
            default:
            begin
                phase_after = PH_HEADER;
            end
        endcase

        push_cmd.open = (phase_after != PH_HEADER);
        phase_next    = phase_after;

        if (code.last_of_chunk)
        begin
            phase_next = PH_HEADER;
            lit_next   = 8'd0;
            rep_next   = 8'd0;
        end

        if (!accept)
        begin
            phase_next = phase_reg;
            lit_next   = lit_reg;
            rep_next   = rep_reg;
        end

        push = accept && (push_cmd.has_data || code.last_of_chunk);
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pbrld_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PackBits run-length decoder command queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module pbrld_queue
    import pbrld_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop,
    output cmd_t      pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pbrld_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PackBits run-length decoder back end
// Counts output bytes against the block length, clips runs, sets status and
// holds the result register.
// ----------------------------------------------------------------------------
module pbrld_back
    import pbrld_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pbrld_cfg_if.sink   cfg,
    input  wire logic   cmd_valid,
    output logic        pop,
    input  wire cmd_t   cmd,
    pbrld_run_if.source run
);

    logic [LEN_W-1:0] block_len_reg, block_len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] room;
    logic [LEN_W-1:0] pos_sum;
    logic [LEN_W-1:0] len_wide;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       value_reg, value_next;
    logic [7:0]       len_reg, len_next;
    logic             done_reg, done_next;
    status_t          status_reg, status_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        block_len_next = block_len_reg;
        if (cfg.valid)
        begin
            if (cfg.block_length == '0)
            begin
                block_len_next = LEN_W'(1);
            end
            else if (cfg.block_length > BLOCK_LEN_MAX)
            begin
                block_len_next = BLOCK_LEN_MAX;
            end
            else
            begin
                block_len_next = cfg.block_length;
            end
        end
    end

    assign pop  = cmd_valid && (!out_valid_reg || run.ready);
    assign room = (pos_reg >= block_len_reg) ? '0 : block_len_reg - pos_reg;

    always_comb
    begin
        len_wide    = '0;
        status_next = ST_OK;
        done_next   = 1'b0;
        if (cmd.has_data)
        begin
            if (room == '0)
            begin
                status_next = ST_TRUNC;
                done_next   = 1'b1;
            end
            else if (LEN_W'(cmd.want) > room)
            begin
                len_wide    = room;
                status_next = ST_TRUNC;
            end
            else
            begin
                len_wide = LEN_W'(cmd.want);
            end
        end
        pos_sum = pos_reg + len_wide;
        if (cmd.has_data && room != '0 && pos_sum >= block_len_reg)
        begin
            done_next = 1'b1;
        end
        len_next   = len_wide[7:0];
        value_next = (len_wide != '0) ? cmd.data : 8'd0;
        pos_next   = pos_sum;

        if (cmd.last)
        begin
            done_next = 1'b1;
            pos_next  = '0;
            if (cmd.open)
            begin
                status_next = ST_MID_RUN;
            end
            else if (pos_sum < block_len_reg)
            begin
                status_next = ST_SHORT;
            end
        end

        if (!pop)
        begin
            pos_next = pos_reg;
        end

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (run.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg <= BLOCK_LEN_RESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            block_len_reg <= block_len_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            value_reg  <= value_next;
            len_reg    <= len_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign run.valid      = out_valid_reg;
    assign run.value      = value_reg;
    assign run.run_length = len_reg;
    assign run.block_done = done_reg;
    assign run.status     = 2'(status_reg);

endmodule
`default_nettype wire

// ----- hw/rtl/packbits_run_length_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PackBits run-length decoder
// Decodes a PackBits-style byte stream into (value, run length) results.
// ----------------------------------------------------------------------------
// Channels: code takes one compressed byte per transaction with a flag on
// the last byte of a chunk; run gives one decoded result per transaction;
// cfg writes the block length, clamped to 1..65536, and is always ready.
// Header bytes give no result except on the last byte of a chunk; every
// literal or repeat value gives exactly one result.
// Throughput: one compressed byte per cycle while code.ready is high; the
// front end registers its phase and the back end its output position.
// A taken byte's command is written into the queue; the back end then loads
// the result register from it once that register is empty or run.ready is
// high.
// Reset: phase, counters and output position clear, the block length
// returns to 14336 and the queue and result register empty.
// Stall: the result register holds while run.ready is low; the two-entry
// queue absorbs up to two more commands before code.ready drops.
// ----------------------------------------------------------------------------
module packbits_run_length_decoder
    import pbrld_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pbrld_code_if.sink  code,
    pbrld_cfg_if.sink   cfg,
    pbrld_run_if.source run
);

    logic push;
    logic push_ready;
    cmd_t push_cmd;
    logic cmd_valid;
    logic pop;
    cmd_t cmd;

    pbrld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code       (code),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    pbrld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop        (pop),
        .pop_cmd    (cmd)
    );

    pbrld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .pop       (pop),
        .cmd       (cmd),
        .run       (run)
    );

endmodule
`default_nettype wire

// ----- sim/tb_packbits_run_length_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits run-length decoder testbench
// Drives compressed chunks into the decoder and checks every decoded
// transaction against an in-bench decoder model. Directed tests cover the
// default length, register clamping, literal and repeat runs, truncation at
// the block end and a length change inside a block. Random well-formed and
// broken chunks follow under several block lengths, with random source gaps
// and sink stalls.
// ----------------------------------------------------------------------------
module tb_packbits_run_length_decoder;
    import pbrld_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] run_length;
        logic       block_done;
        status_t    status;
    } run_result_t;

    logic clk;
    logic rst_n;

    pbrld_code_if code_ch ();
    pbrld_cfg_if  cfg_ch ();
    pbrld_run_if  run_ch ();

    packbits_run_length_decoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .code  (code_ch),
        .cfg   (cfg_ch),
        .run   (run_ch)
    );

    phase_t      m_phase;
    logic [8:0]  m_lit_left;
    logic [8:0]  m_rep_count;
    logic [16:0] m_out_pos;
    logic [16:0] m_block_len;

    run_result_t expected_runs[$];
    int          errors;
    int          rand_items;
    bit          gaps_on;
    bit          stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic decode_byte(input logic [7:0] b, input logic last,
                                         output run_result_t r);
        logic [16:0] room;
        logic [8:0]  want;
        logic [16:0] len;
        logic        have;
        have = 1'b0;
        len  = '0;
        r = '{value: 8'h00, run_length: 8'h00, block_done: 1'b0, status: ST_OK};
        if (m_phase == PH_HEADER)
        begin
            if (b[7])
            begin
                m_rep_count = 9'(257 - int'(b));
                m_phase = PH_REPEAT;
            end
            else
            begin
                m_lit_left = 9'(b) + 9'd1;
                m_phase = PH_LITERAL;
            end
        end
        else
        begin
            room = (m_out_pos >= m_block_len) ? 17'd0 : m_block_len - m_out_pos;
            if (m_phase == PH_REPEAT)
            begin
                want = m_rep_count;
                m_rep_count = '0;
                m_phase = PH_HEADER;
            end
            else
            begin
                want = 9'd1;
                if (m_lit_left > 0)
                    m_lit_left = m_lit_left - 9'd1;
                if (m_lit_left == 0)
                    m_phase = PH_HEADER;
            end
            have = 1'b1;
            if (room == 0)
            begin
                r.status = ST_TRUNC;
                r.block_done = 1'b1;
            end
            else
            begin
                if (17'(want) > room)
                begin
                    len = room;
                    r.status = ST_TRUNC;
                end
                else
                    len = 17'(want);
                m_out_pos = m_out_pos + len;
                if (m_out_pos >= m_block_len)
                    r.block_done = 1'b1;
            end
            r.run_length = len[7:0];
            r.value = (len != 0) ? b : 8'h00;
        end
        if (last)
        begin
            have = 1'b1;
            r.block_done = 1'b1;
            if (m_phase != PH_HEADER)
                r.status = ST_MID_RUN;
            else if (m_out_pos < m_block_len)
                r.status = ST_SHORT;
            m_phase = PH_HEADER;
            m_lit_left = '0;
            m_rep_count = '0;
            m_out_pos = '0;
        end
        return have;
    endfunction

    task automatic send_code(input logic [7:0] b, input logic last);
        int          gap;
        run_result_t r;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            repeat (gap)
            begin
                code_ch.valid = 1'b0;
                code_ch.code_byte = 8'($urandom);
                code_ch.last_of_chunk = 1'($urandom);
                @(negedge clk);
            end
        end
        code_ch.valid = 1'b1;
        code_ch.code_byte = b;
        code_ch.last_of_chunk = last;
        do
            @(posedge clk);
        while (!code_ch.ready);
        if (decode_byte(b, last, r))
            expected_runs.push_back(r);
    endtask

    task automatic settle();
        @(negedge clk);
        code_ch.valid = 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_block_length(input logic [16:0] v);
        settle();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.block_length = v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (v == 0)
            m_block_len = 17'd1;
        else if (v > BLOCK_LEN_MAX)
            m_block_len = BLOCK_LEN_MAX;
        else
            m_block_len = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        cfg_ch.block_length = 17'($urandom);
    endtask

    // stall the result channel in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        run_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                run_ch.ready = 1'b0;
                stall_left--;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                run_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end
            else
                run_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        run_result_t e;
        if (rst_n && run_ch.valid && run_ch.ready)
        begin
            if (expected_runs.size() == 0)
            begin
                $display("%0t: unexpected transaction value=%0d run_length=%0d done=%0b st=%0d",
                         $time, run_ch.value, run_ch.run_length, run_ch.block_done,
                         run_ch.status);
                errors++;
            end
            else
            begin
                e = expected_runs.pop_front();
                if (run_ch.value !== e.value)
                begin
                    $display("%0t: value expected %0d actual %0d", $time, e.value, run_ch.value);
                    errors++;
                end
                if (run_ch.run_length !== e.run_length)
                begin
                    $display("%0t: run_length expected %0d actual %0d", $time, e.run_length,
                             run_ch.run_length);
                    errors++;
                end
                if (run_ch.block_done !== e.block_done)
                begin
                    $display("%0t: block_done expected %0b actual %0b", $time, e.block_done,
                             run_ch.block_done);
                    errors++;
                end
                if (run_ch.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             run_ch.status);
                    errors++;
                end
            end
        end
    end

    task automatic test_default_length();
        send_code(8'h80, 1'b0);
        send_code(8'h00, 1'b0);
        send_code(8'h00, 1'b0);
        send_code(8'hFF, 1'b1);
    endtask

    task automatic test_length_clamp();
        write_block_length(17'd0);
        send_code(8'hFE, 1'b0);
        send_code(8'h12, 1'b0);
        send_code(8'h00, 1'b1);
        write_block_length(17'h1FFFF);
        send_code(8'h81, 1'b0);
        send_code(8'hC3, 1'b0);
        write_block_length(17'd65536);
        send_code(8'h7F, 1'b1);
    endtask

    task automatic test_literal_and_repeat();
        write_block_length(17'd5);
        send_code(8'h02, 1'b0);
        send_code(8'h01, 1'b0);
        send_code(8'h02, 1'b0);
        send_code(8'h03, 1'b0);
        send_code(8'hFF, 1'b0);
        send_code(8'h80, 1'b0);
        send_code(8'h00, 1'b0);
        send_code(8'h77, 1'b0);
        send_code(8'h01, 1'b0);
        send_code(8'h44, 1'b1);
    endtask

    task automatic test_length_change_mid_block();
        write_block_length(17'd8);
        send_code(8'hFD, 1'b0);
        send_code(8'h11, 1'b0);
        write_block_length(17'd3);
        send_code(8'h00, 1'b0);
        send_code(8'h22, 1'b0);
        send_code(8'hFF, 1'b0);
        send_code(8'h33, 1'b1);
    endtask

    task automatic test_random_chunks();
        logic [7:0]  chunk[$];
        logic [16:0] len_sel;
        int          phase_items;
        int          target;
        int          remaining;
        int          cnt;
        int          kind;
        int          p;
        p = 0;
        while (rand_items < 1050)
        begin
            if (rand_items >= 900)
            begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            case (p % 6)
                0: len_sel = 17'($urandom_range(1, 16));
                1: len_sel = 17'($urandom_range(17, 300));
                2: len_sel = 17'd65536;
                3: len_sel = 17'd0;
                4: len_sel = 17'h1FFFF;
                default: len_sel = 17'($urandom_range(1, 600));
            endcase
            write_block_length(len_sel);
            phase_items = 0;
            while (phase_items < 140 && rand_items < 1050)
            begin
                if (m_block_len <= 400 && $urandom_range(0, 4) != 0)
                    target = m_block_len;
                else
                    target = $urandom_range(1, 400);
                if ($urandom_range(0, 6) == 0)
                    target += $urandom_range(1, 40);
                chunk.delete();
                remaining = target;
                while (remaining > 0)
                begin
                    if (remaining >= 2 && $urandom_range(0, 1) == 1)
                    begin
                        cnt = $urandom_range(2, (remaining < 129) ? remaining : 129);
                        chunk.push_back(8'(257 - cnt));
                        chunk.push_back(8'($urandom));
                    end
                    else
                    begin
                        cnt = $urandom_range(1, (remaining < 128) ? remaining : 128);
                        chunk.push_back(8'(cnt - 1));
                        repeat (cnt) chunk.push_back(8'($urandom));
                    end
                    remaining -= cnt;
                end
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    chunk = chunk[0:$urandom_range(0, chunk.size() - 1)];
                else if (kind == 1)
                    repeat ($urandom_range(1, 6)) chunk.push_back(8'($urandom));
                else if (kind == 2)
                    repeat ($urandom_range(1, 6)) chunk.push_front(8'($urandom));
                foreach (chunk[i])
                begin
                    send_code(chunk[i], i == chunk.size() - 1);
                    phase_items++;
                    rand_items++;
                end
            end
            p++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        code_ch.valid = 1'b0;
        code_ch.code_byte = 8'h00;
        code_ch.last_of_chunk = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.block_length = 17'd0;
        errors = 0;
        rand_items = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        m_phase = PH_HEADER;
        m_lit_left = '0;
        m_rep_count = '0;
        m_out_pos = '0;
        m_block_len = BLOCK_LEN_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_length();
        test_length_clamp();
        test_literal_and_repeat();
        test_length_change_mid_block();
        test_random_chunks();

        @(negedge clk);
        code_ch.valid = 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pbrld_pkg.sv
hw/rtl/pbrld_ifs.sv
hw/rtl/pbrld_front.sv
hw/rtl/pbrld_queue.sv
hw/rtl/pbrld_back.sv
hw/rtl/packbits_run_length_decoder.sv
sim/tb_packbits_run_length_decoder.sv
